// ----- src/ugcr_pkg.sv -----
package ugcr_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLIP_A,
    S_CLIP_B,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALL = 2'd1,
    ST_GONE  = 2'd2
  } status_t;

  // Source of the reply bytes
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_DEV,
    SRC_CFG,
    SRC_CAP,
    SRC_CONF,
    SRC_STAT,
    SRC_ZERO
  } src_t;

  // bmRequestType type field
  localparam logic [1:0] KIND_STD    = 2'd0;
  localparam logic [1:0] KIND_CLASS  = 2'd1;
  localparam logic [1:0] KIND_VENDOR = 2'd2;

  localparam logic [4:0] RCP_ENDPOINT = 5'd2;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

  // Class and vendor request codes
  localparam logic [7:0] VREQ_CAP_A   = 8'h01;
  localparam logic [7:0] VREQ_CAP_B   = 8'h06;
  localparam logic [7:0] VREQ_RUMBLE  = 8'h09;

  // Descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_CAP    = 8'h42;

  localparam logic [5:0] DEV_SIZE = 6'd18;
  localparam logic [5:0] CFG_SIZE = 6'd32;
  localparam logic [5:0] CAP_SIZE = 6'd16;

  localparam logic [15:0] RUMBLE_MIN_LEN = 16'd6;
  localparam logic [6:0]  ADDR_MASK      = 7'h7F;

  // Device descriptor, padded with zeros past its 18 bytes
  localparam logic [7:0] DEV_ROM [32] = '{
    8'd18, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
    8'h5E, 8'h04, 8'h89, 8'h02, 8'h00, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] CFG_ROM [32] = '{
    8'd9,  8'h02, 8'd32, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80,
    8'h32, 8'd9,  8'h04, 8'h00, 8'h00, 8'h02, 8'h58, 8'h42,
    8'h00, 8'h00, 8'd7,  8'h05, 8'h81, 8'h03, 8'h20, 8'h00,
    8'h04, 8'd7,  8'h05, 8'h02, 8'h03, 8'h20, 8'h00, 8'h04
  };

  localparam logic [7:0] CAP_ROM [16] = '{
    8'd16, 8'h42, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14, 8'h06,
    8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic [15:0] host_buffer_size;
    logic [15:0] payload_length;
    logic [15:0] payload_left_level;
    logic [15:0] payload_right_level;
    logic        attached;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        last;
    logic [6:0]  device_address;
    logic [7:0]  active_configuration;
    logic        endpoint_halted;
    logic [15:0] rumble_left;
    logic [15:0] rumble_right;
  } rsp_t;

endpackage

// ----- src/ugcr_if.sv -----
interface ugcr_req_if import ugcr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ugcr_rsp_if import ugcr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/usb_gamepad_control_request_responder.sv -----
// Control-request responder of a USB gamepad.
// req (sink): one setup request per word, with wLength, the room in the
//   host IN buffer, the OUT payload length and rumble levels, and the
//   attach flag. Accepted when valid and ready are both high.
// rsp (source): one word per reply byte, in order; a reply with no data,
//   a stall or a detached device gives a single word. last marks the final
//   word; every word carries the device state as it stands after the request.
// Timing: a request is accepted in IDLE, decoded in DECODE, then the
//   reply length is clipped in two passes through one shared 16-bit
//   comparator (wLength against buffer room, then against reply size).
//   Reply words follow at one per cycle while rsp.ready is high; once the
//   last word is taken the block returns to IDLE. The number of reply
//   bytes is at most 32.
// One request is in flight at a time; req.ready is low until the last
// reply word has been taken.
// Stall: a word held on rsp stays stable until taken; the sequencer waits.
// Reset: synchronous, active high; returns to IDLE and clears the address,
//   configuration, halt flag and both rumble levels.
module usb_gamepad_control_request_responder import ugcr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ugcr_req_if.sink     req,
  ugcr_rsp_if.source   rsp
);

  state_t state, state_next;

  // Captured request
  req_t rq;

  // Device state
  logic [6:0]  address_reg;
  logic [7:0]  configuration_reg;
  logic        halt_flag;
  logic [15:0] left_motor_level;
  logic [15:0] right_motor_level;

  // Reply setup
  status_t     status;
  src_t        src;
  logic [5:0]  cap;        // reply size before clipping
  logic        clip;       // clip to wLength and buffer room
  logic        use_plen;   // byte_count reports the OUT payload length
  logic        stat_bit;   // first byte of a get-status reply
  logic [15:0] lim;
  logic [5:0]  n;
  logic [15:0] count;
  logic [4:0]  idx;

  // Decode of the captured request
  logic [1:0]  kind;
  logic [4:0]  recip;
  logic        ep_feature;
  status_t     d_status;
  src_t        d_src;
  logic [5:0]  d_cap;
  logic        d_clip;
  logic        d_plen;
  logic        d_set_addr;
  logic        d_set_cfg;
  logic        d_set_halt;
  logic        d_clr_halt;
  logic        d_rumble;

  // Shared comparator
  logic [15:0] cmp_a;
  logic [15:0] cmp_b;
  logic        cmp_lt;

  logic [7:0]  byte_sel;
  logic        last_word;
  logic        req_fire;
  logic        rsp_fire;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  assign kind       = rq.request_type[6:5];
  assign recip      = rq.request_type[4:0];
  assign ep_feature = (recip == RCP_ENDPOINT) && (rq.request_value == 16'd0);

  always_comb begin
    d_status   = ST_STALL;
    d_src      = SRC_NONE;
    d_cap      = 6'd0;
    d_clip     = 1'b0;
    d_plen     = 1'b0;
    d_set_addr = 1'b0;
    d_set_cfg  = 1'b0;
    d_set_halt = 1'b0;
    d_clr_halt = 1'b0;
    d_rumble   = 1'b0;
    if (!rq.attached) begin
      d_status = ST_GONE;
    end else if (kind == KIND_STD) begin
      d_status = ST_OK;
      case (rq.request_code)
        REQ_GET_DESCRIPTOR: begin
          d_clip = 1'b1;
          case (rq.request_value[15:8])
            DT_DEVICE: begin
              d_src = SRC_DEV;
              d_cap = DEV_SIZE;
            end
            DT_CONFIG: begin
              d_src = SRC_CFG;
              d_cap = CFG_SIZE;
            end
            DT_CAP: begin
              d_src = SRC_CAP;
              d_cap = CAP_SIZE;
            end
            default: begin
              d_status = ST_STALL;
              d_clip   = 1'b0;
            end
          endcase
        end
        REQ_SET_ADDRESS: d_set_addr = 1'b1;
        REQ_GET_CONFIG: begin
          if (rq.host_buffer_size != 16'd0) begin
            d_src = SRC_CONF;
            d_cap = 6'd1;
          end
        end
        REQ_SET_CONFIG: d_set_cfg = 1'b1;
        REQ_GET_STATUS: begin
          if (rq.host_buffer_size >= 16'd2) begin
            d_src = SRC_STAT;
            d_cap = 6'd2;
          end
        end
        REQ_CLEAR_FEATURE: d_clr_halt = ep_feature;
        REQ_SET_FEATURE:   d_set_halt = ep_feature;
        REQ_GET_INTERFACE: begin
          if (rq.host_buffer_size != 16'd0) begin
            d_src = SRC_ZERO;
            d_cap = 6'd1;
          end
        end
        REQ_SET_INTERFACE: d_status = ST_OK;
        default:           d_status = ST_STALL;
      endcase
    end else if (kind == KIND_CLASS || kind == KIND_VENDOR) begin
      d_status = ST_OK;
      case (rq.request_code)
        VREQ_CAP_A, VREQ_CAP_B: begin
          d_src  = SRC_CAP;
          d_cap  = CAP_SIZE;
          d_clip = 1'b1;
        end
        VREQ_RUMBLE: begin
          if (rq.payload_length >= RUMBLE_MIN_LEN) begin
            d_rumble = 1'b1;
            d_plen   = 1'b1;
          end
        end
        default: d_status = ST_STALL;
      endcase
    end
  end

  // Operand select of the shared comparator
  always_comb begin
    case (state)
      S_CLIP_A: begin
        cmp_a = rq.request_length;
        cmp_b = rq.host_buffer_size;
      end
      default: begin
        cmp_a = lim;
        cmp_b = {10'd0, cap};
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign last_word = (n == 6'd0) || ({1'b0, idx} + 6'd1 == n);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_fire) state_next = S_DECODE;
      S_DECODE: state_next = S_CLIP_A;
      S_CLIP_A: state_next = S_CLIP_B;
      S_CLIP_B: state_next = S_SEND;
      S_SEND:   if (rsp_fire && last_word) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      S_IDLE:  req.ready = 1'b1;
      S_SEND:  rsp.valid = 1'b1;
      default: begin
        req.ready = 1'b0;
        rsp.valid = 1'b0;
      end
    endcase
  end

  // Reply byte
  always_comb begin
    case (src)
      SRC_DEV:  byte_sel = DEV_ROM[idx];
      SRC_CFG:  byte_sel = CFG_ROM[idx];
      SRC_CAP:  byte_sel = CAP_ROM[idx[3:0]];
      SRC_CONF: byte_sel = configuration_reg;
      SRC_STAT: byte_sel = {7'd0, stat_bit && (idx == 5'd0)};
      default:  byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    rsp.data.status               = status;
    rsp.data.byte_count           = count;
    rsp.data.data_valid           = (n != 6'd0);
    rsp.data.data_byte            = (n != 6'd0) ? byte_sel : 8'h00;
    rsp.data.last                 = last_word;
    rsp.data.device_address       = address_reg;
    rsp.data.active_configuration = configuration_reg;
    rsp.data.endpoint_halted      = halt_flag;
    rsp.data.rumble_left          = left_motor_level;
    rsp.data.rumble_right         = right_motor_level;
  end

  // Control and device state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      address_reg       <= 7'd0;
      configuration_reg <= 8'd0;
      halt_flag         <= 1'b0;
      left_motor_level  <= 16'd0;
      right_motor_level <= 16'd0;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        if (d_set_addr) address_reg <= rq.request_value[6:0] & ADDR_MASK;
        if (d_set_cfg)  configuration_reg <= rq.request_value[7:0];
        if (d_set_halt) halt_flag <= 1'b1;
        if (d_clr_halt) halt_flag <= 1'b0;
        if (d_rumble) begin
          left_motor_level  <= rq.payload_left_level;
          right_motor_level <= rq.payload_right_level;
        end
      end
    end
  end

  // Request capture and reply sequencing
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) rq <= req.data;
      end
      S_DECODE: begin
        status   <= d_status;
        src      <= d_src;
        cap      <= d_cap;
        clip     <= d_clip;
        use_plen <= d_plen;
        stat_bit <= (recip == RCP_ENDPOINT) && halt_flag;
      end
      S_CLIP_A: begin
        // take the smaller of wLength and the buffer room, or no limit when not clipping
        if (!clip)       lim <= 16'hFFFF;
        else if (cmp_lt) lim <= rq.request_length;
        else             lim <= rq.host_buffer_size;
      end
      S_CLIP_B: begin
        // then clip against the reply size
        n     <= cmp_lt ? lim[5:0] : cap;
        count <= use_plen ? rq.payload_length
                          : {10'd0, (cmp_lt ? lim[5:0] : cap)};
        idx   <= 5'd0;
      end
      S_SEND: begin
        if (rsp_fire && !last_word) idx <= idx + 5'd1;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Busy while a reply is pending
  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !req.ready)
    else $error("request taken while a reply is pending");

  // Data bytes come only with a successful reply
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.data_valid) |-> (rsp.data.status == ST_OK))
    else $error("data byte on a failed request");

  // A reply without data is a single word
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.data_valid) |-> rsp.data.last)
    else $error("empty reply not marked last");

  // The last word taken frees the block for the next request
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.data.last) |=> req.ready)
    else $error("not ready after last reply word");

endmodule
